// ----- sv/utf8_stream_decoder_defines.svh -----
// Assertion macros shared by the decoder RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define UTF8SD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define UTF8SD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UTF8SD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define UTF8SD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- sv/utf8sd_pkg.sv -----
// Types, status codes and decode helpers for the UTF-8 stream decoder.
// No dependencies; imported by every decoder module.
`default_nettype none

package utf8sd_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
	localparam logic [2:0] ST_BROKEN    = 3'd2;
	localparam logic [2:0] ST_OVERLONG  = 3'd3;
	localparam logic [2:0] ST_STRICT    = 3'd4;
	localparam logic [2:0] ST_TRUNCATED = 3'd5;

	localparam logic [30:0] UNICODE_MAX = 31'h0010_FFFF;
	localparam logic [30:0] SURR_LO     = 31'h0000_D800;
	localparam logic [30:0] SURR_HI     = 31'h0000_DFFF;

	localparam int RESQ_AW = 2;

	typedef struct packed {
		logic [30:0] code_point;
		logic [2:0]  status;
		logic [2:0]  seq_bytes;
		logic        last_result;
	} res_t;

	typedef struct packed {
		logic [30:0] acc;
		logic [2:0]  rem;
		logic [2:0]  len;
	} dec_state_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		logic       hit;
		res_t       r;
		dec_state_t st;
	} idle_t;

	function automatic logic [30:0] min_for_len(input logic [2:0] len);
		logic [30:0] m;
		unique case (len)
			3'd2:    m = 31'h0000_0080;
			3'd3:    m = 31'h0000_0800;
			3'd4:    m = 31'h0001_0000;
			3'd5:    m = 31'h0020_0000;
			3'd6:    m = 31'h0400_0000;
			default: m = 31'd0;
		endcase
		return m;
	endfunction

	// byte seen with no sequence open
	function automatic idle_t idle_step(input logic [7:0] b, input logic eos);
		idle_t      o;
		logic [2:0] len;
		logic [7:0] mask;
		o    = '0;
		len  = 3'd0;
		mask = 8'd0;
		priority if (!b[7]) begin
			o.hit          = 1'b1;
			o.r.code_point = {23'd0, b};
			o.r.status     = ST_OK;
			o.r.seq_bytes  = 3'd1;
		end else if (!b[6] || b[7:1] == 7'h7F) begin
			o.hit         = 1'b1;
			o.r.status    = ST_BAD_LEAD;
			o.r.seq_bytes = 3'd1;
		end else begin
			priority if (!b[5]) begin
				len = 3'd2;
			end else if (!b[4]) begin
				len = 3'd3;
			end else if (!b[3]) begin
				len = 3'd4;
			end else if (!b[2]) begin
				len = 3'd5;
			end else begin
				len = 3'd6;
			end
			if (eos) begin
				o.hit         = 1'b1;
				o.r.status    = ST_TRUNCATED;
				o.r.seq_bytes = 3'd1;
			end else begin
				mask     = 8'h7F >> len;
				o.st.acc = {23'd0, b & mask};
				o.st.rem = len - 3'd1;
				o.st.len = len;
			end
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ----- sv/utf8sd_ifs.sv -----
// Channel interfaces: byte stream in, results out, strict-mode config.
// Standalone; used by the decoder top level and its submodules.
`default_nettype none

interface utf8sd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;
	modport source (output valid, data_byte, end_of_stream, input ready);
	modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface utf8sd_res_if;
	logic        valid;
	logic        ready;
	logic [30:0] code_point;
	logic [2:0]  status;
	logic [2:0]  seq_bytes;
	logic        last_result;
	modport source (output valid, code_point, status, seq_bytes, last_result, input ready);
	modport sink (input valid, code_point, status, seq_bytes, last_result, output ready);
endinterface

interface utf8sd_cfg_if;
	logic valid;
	logic ready;
	logic strict_mode;
	modport source (output valid, strict_mode, input ready);
	modport sink (input valid, strict_mode, output ready);
endinterface

`default_nettype wire

// ----- sv/utf8_stream_decoder.sv -----
// UTF-8 stream decoder (sequences up to six bytes), one byte per beat.
// A result is offered from the result queue once its byte has left the input register.
// Throughput: one byte per cycle while the four-entry result queue has room for two more
// results; results leave one per cycle when taken, and a fuller queue stalls the input.
// Reset: decoder idle, strict mode 1, queue empty; no clearing pass.
`default_nettype none

module utf8_stream_decoder (
	input  wire logic     clk,
	input  wire logic     arst_n,
	utf8sd_byte_if.sink   stream,
	utf8sd_cfg_if.sink    cfg,
	utf8sd_res_if.source  result
);
	import utf8sd_pkg::*;

	push_t push;
	logic  space;

	utf8sd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.cfg    (cfg),
		.space  (space),
		.push   (push)
	);

	utf8sd_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.space  (space),
		.result (result)
	);

endmodule

`default_nettype wire

// ----- sv/utf8sd_core.sv -----
// Input register, decoder state and single-pass decode of one byte.
// Depends on utf8sd_pkg and utf8sd_ifs; pushes up to two results per beat.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

module utf8sd_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	utf8sd_byte_if.sink               stream,
	utf8sd_cfg_if.sink                cfg,
	input  wire logic                 space,
	output utf8sd_pkg::push_t         push
);
	import utf8sd_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       strict_q;
	dec_state_t st_q;
	dec_state_t st_d;
	logic       fire;
	logic       cont;
	idle_t      idle_r;
	logic [30:0] acc_sh;
	logic [2:0]  rem_m1;
	logic [1:0]  n;
	res_t        r0;
	res_t        r1;

	assign fire         = v_s1 && space;
	assign stream.ready = !v_s1 || fire;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			strict_q <= 1'b1;
			st_q     <= '0;
		end else begin
			if (stream.valid && stream.ready) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (cfg.valid) begin
				strict_q <= cfg.strict_mode;
			end
			if (fire) begin
				st_q <= st_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.data_byte;
			eos_s1  <= stream.end_of_stream;
		end
	end

	always_comb begin
		cont   = byte_s1[7:6] == 2'b10;
		idle_r = idle_step(byte_s1, eos_s1);
		acc_sh = {st_q.acc[24:0], byte_s1[5:0]};
		rem_m1 = st_q.rem - 3'd1;
		st_d   = st_q;
		n      = 2'd0;
		r0     = '0;
		r1     = '0;
		if (st_q.rem == 3'd0) begin
			st_d = idle_r.st;
			n    = idle_r.hit ? 2'd1 : 2'd0;
			r0   = idle_r.r;
		end else if (cont) begin
			if (rem_m1 == 3'd0) begin
				st_d         = '0;
				n            = 2'd1;
				r0.seq_bytes = st_q.len;
				priority if (acc_sh < min_for_len(st_q.len)) begin
					r0.status = ST_OVERLONG;
				end else if (strict_q && (acc_sh > UNICODE_MAX ||
						(acc_sh >= SURR_LO && acc_sh <= SURR_HI))) begin
					r0.status = ST_STRICT;
				end else begin
					r0.status     = ST_OK;
					r0.code_point = acc_sh;
				end
			end else if (eos_s1) begin
				st_d         = '0;
				n            = 2'd1;
				r0.status    = ST_TRUNCATED;
				r0.seq_bytes = st_q.len - rem_m1;
			end else begin
				st_d.acc = acc_sh;
				st_d.rem = rem_m1;
			end
		end else begin
			// broken sequence, then the byte starts over as a fresh one
			st_d         = idle_r.st;
			r0.status    = ST_BROKEN;
			r0.seq_bytes = st_q.len - st_q.rem;
			r1           = idle_r.r;
			n            = idle_r.hit ? 2'd2 : 2'd1;
		end
		r0.last_result = n == 2'd1;
		r1.last_result = 1'b1;
		push.n  = fire ? n : 2'd0;
		push.r0 = r0;
		push.r1 = r1;
	end

	`UTF8SD_ASSERT_IMP(a_open_len, clk, arst_n, st_q.rem != 3'd0,
		st_q.len > st_q.rem && st_q.len <= 3'd6, "open sequence length inconsistent")
	`UTF8SD_ASSERT_IMP(a_idle_clear, clk, arst_n, st_q.rem == 3'd0,
		st_q.acc == 31'd0 && st_q.len == 3'd0, "idle decoder holds stale state")
	`UTF8SD_ASSERT_NXT(a_hold_s1, clk, arst_n, v_s1 && !space,
		v_s1 && $stable(byte_s1) && $stable(st_q), "stalled byte or state changed")

endmodule

`default_nettype wire

// ----- sv/utf8sd_resq.sv -----
// Result queue: takes up to two results per cycle, delivers one per beat.
// Depends on utf8sd_pkg and utf8sd_ifs; the head entry is the output register.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

module utf8sd_resq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire utf8sd_pkg::push_t    push,
	output logic                      space,
	utf8sd_res_if.source              result
);
	import utf8sd_pkg::*;

	localparam int Depth = 1 << RESQ_AW;

	res_t               mem [Depth];
	logic [RESQ_AW-1:0] wr_q;
	logic [RESQ_AW-1:0] rd_q;
	logic [RESQ_AW:0]   cnt_q;
	logic               pop;
	res_t               head;

	assign pop   = result.valid && result.ready;
	assign space = cnt_q <= (RESQ_AW + 1)'(Depth - 2);
	assign head  = mem[rd_q];

	assign result.valid       = cnt_q != '0;
	assign result.code_point  = head.code_point;
	assign result.status      = head.status;
	assign result.seq_bytes   = head.seq_bytes;
	assign result.last_result = head.last_result;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_q + RESQ_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RESQ_AW'(push.n);
			rd_q  <= rd_q + RESQ_AW'(pop);
			cnt_q <= cnt_q + (RESQ_AW + 1)'(push.n) - (RESQ_AW + 1)'(pop);
		end
	end

	`UTF8SD_ASSERT_IMP(a_push_room, clk, arst_n, push.n != 2'd0,
		push.n != 2'd3 && space, "push without room")
	`UTF8SD_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1,
		cnt_q <= (RESQ_AW + 1)'(Depth), "queue count out of range")
	`UTF8SD_ASSERT_NXT(a_head_hold, clk, arst_n, result.valid && !result.ready,
		result.valid && $stable(head), "stalled result beat changed")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for utf8_stream_decoder: byte beats in, decoded results out.
// Needs utf8sd_pkg and the utf8sd_*_if interfaces; predicts every result internally
// and compares each one against the oldest pending prediction.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import utf8sd_pkg::*;

	localparam int LIMIT        = 1_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 6;

	logic clk;
	logic arst_n;

	utf8sd_byte_if stream_if();
	utf8sd_cfg_if  cfg_if();
	utf8sd_res_if  res_if();

	utf8_stream_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.cfg    (cfg_if),
		.result (res_if)
	);

	// decoder mirror
	logic [30:0] acc_m;
	logic [2:0]  rem_m;
	logic [2:0]  len_m;
	logic        strict_m;

	res_t pending_decodes[$];
	int   mismatches;
	int   bytes_sent;
	int   results_seen;
	int   seen_status[8];
	int   cycles;
	bit   src_quiet;
	bit   snk_quiet;
	bit   hold_request;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [30:0] floor_for(input logic [2:0] n);
		case (n)
			3'd2:    return 31'h0000_0080;
			3'd3:    return 31'h0000_0800;
			3'd4:    return 31'h0001_0000;
			3'd5:    return 31'h0020_0000;
			3'd6:    return 31'h0400_0000;
			default: return 31'd0;
		endcase
	endfunction

	function automatic res_t make_res(input logic [30:0] cp, input logic [2:0] st,
			input logic [2:0] nb);
		res_t r;
		r             = '0;
		r.code_point  = cp;
		r.status      = st;
		r.seq_bytes   = nb;
		return r;
	endfunction

	function automatic void clear_seq();
		acc_m = '0;
		rem_m = '0;
		len_m = '0;
	endfunction

	// byte with no sequence open; hit=0 means a new sequence was opened
	function automatic void take_lead(input logic [7:0] b, input logic eos,
			output bit hit, output res_t r);
		logic [2:0] n;
		hit = 1'b1;
		r   = make_res('0, ST_BAD_LEAD, 3'd1);
		n   = 3'd0;
		casez (b)
			8'b0???????: r = make_res({23'd0, b}, ST_OK, 3'd1);
			8'b10??????, 8'b1111111?: r = make_res('0, ST_BAD_LEAD, 3'd1);
			default: begin
				casez (b)
					8'b110?????: n = 3'd2;
					8'b1110????: n = 3'd3;
					8'b11110???: n = 3'd4;
					8'b111110??: n = 3'd5;
					default:     n = 3'd6;
				endcase
				if (eos) begin
					r = make_res('0, ST_TRUNCATED, 3'd1);
					clear_seq();
				end else begin
					hit   = 1'b0;
					acc_m = {23'd0, b & (8'h7F >> n)};
					rem_m = n - 3'd1;
					len_m = n;
				end
			end
		endcase
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eos);
		res_t outs[$];
		res_t r;
		bit   hit;
		logic [30:0] v;
		if (rem_m == 3'd0) begin
			take_lead(b, eos, hit, r);
			if (hit)
				outs.push_back(r);
		end else if (b[7:6] == 2'b10) begin
			acc_m = {acc_m[24:0], b[5:0]};
			rem_m = rem_m - 3'd1;
			if (rem_m == 3'd0) begin
				v = acc_m;
				if (v < floor_for(len_m))
					outs.push_back(make_res('0, ST_OVERLONG, len_m));
				else if (strict_m && (v > UNICODE_MAX || (v >= SURR_LO && v <= SURR_HI)))
					outs.push_back(make_res('0, ST_STRICT, len_m));
				else
					outs.push_back(make_res(v, ST_OK, len_m));
				clear_seq();
			end else if (eos) begin
				outs.push_back(make_res('0, ST_TRUNCATED, len_m - rem_m));
				clear_seq();
			end
		end else begin
			outs.push_back(make_res('0, ST_BROKEN, len_m - rem_m));
			clear_seq();
			take_lead(b, eos, hit, r);
			if (hit)
				outs.push_back(r);
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last_result = 1'b1;
		foreach (outs[i]) begin
			seen_status[outs[i].status]++;
			pending_decodes.push_back(outs[i]);
		end
	endfunction

	always @(posedge clk) begin : check_result
		res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			results_seen++;
			if (pending_decodes.size() == 0) begin
				$error("unexpected result: code_point %h status %0d seq_bytes %0d",
					res_if.code_point, res_if.status, res_if.seq_bytes);
				mismatches++;
			end else begin
				want = pending_decodes.pop_front();
				if (res_if.code_point !== want.code_point) begin
					$error("code_point: expected %h, got %h", want.code_point,
						res_if.code_point);
					mismatches++;
				end
				if (res_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_if.status);
					mismatches++;
				end
				if (res_if.seq_bytes !== want.seq_bytes) begin
					$error("seq_bytes: expected %0d, got %0d", want.seq_bytes,
						res_if.seq_bytes);
					mismatches++;
				end
				if (res_if.last_result !== want.last_result) begin
					$error("last_result: expected %0d, got %0d", want.last_result,
						res_if.last_result);
					mismatches++;
				end
			end
		end
	end

	initial begin : result_sink
		int stall_left;
		int run_left;
		stall_left   = 0;
		run_left     = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (snk_quiet) begin
				res_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else if (run_left > 0) begin
				res_if.ready <= 1'b1;
				run_left--;
			end else begin
				stall_left = pick_gap(1'b0);
				run_left   = $urandom_range(1, 16);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eos);
		int gap;
		stream_if.valid         <= 1'b1;
		stream_if.data_byte     <= b;
		stream_if.end_of_stream <= eos;
		do @(posedge clk); while (!stream_if.ready);
		decode_byte(b, eos);
		bytes_sent++;
		gap = pick_gap(src_quiet);
		if (gap > 0) begin
			stream_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sends the first keep beats of the n-byte encoding of cp
	task automatic send_code(input logic [31:0] cp, input int n, input int keep,
			input bit eos);
		logic [7:0] enc[6];
		int i;
		if (n == 1) begin
			enc[0] = {1'b0, cp[6:0]};
		end else begin
			enc[0] = (8'hFF << (8 - n)) | (8'(cp >> (6 * (n - 1))) & (8'h7F >> n));
			for (i = 1; i < n; i++)
				enc[i] = 8'h80 | 8'((cp >> (6 * (n - 1 - i))) & 32'h3F);
		end
		for (i = 0; i < keep; i++)
			send_byte(enc[i], eos && i == keep - 1);
	endtask

	task automatic drain();
		stream_if.valid <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_strict(input logic v);
		drain();
		cfg_if.valid       <= 1'b1;
		cfg_if.strict_mode <= v;
		do @(posedge clk); while (!cfg_if.ready);
		strict_m = v;
		cfg_if.valid <= 1'b0;
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 1;
		if (r < 50) return 2;
		if (r < 70) return 3;
		if (r < 85) return 4;
		if (r < 93) return 5;
		return 6;
	endfunction

	function automatic logic [31:0] pick_cp(input int n);
		logic [31:0] span;
		logic [31:0] v;
		int r;
		span = (32'd1 << ((n == 1) ? 7 : 5 * n + 1)) - 32'd1;
		r    = $urandom_range(0, 9);
		if (r < 5) begin
			v = $urandom & span;
		end else if (r < 8) begin
			case ($urandom_range(0, 9))
				0: v = 32'd0;
				1: v = {1'b0, floor_for(3'(n))};
				2: v = {1'b0, floor_for(3'(n))} - 32'd1;
				3: v = span;
				4: v = 32'h0000_D7FF;
				5: v = 32'h0000_D800;
				6: v = 32'h0000_DFFF;
				7: v = 32'h0000_E000;
				8: v = 32'h0010_FFFF;
				default: v = 32'h0011_0000;
			endcase
			v &= span;
		end else begin
			v = $urandom & (span >> 5);
		end
		return v;
	endfunction

	task automatic random_stream(input int n_bytes);
		int stop_at;
		int n;
		int r;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				n = pick_len();
				send_code(pick_cp(n), n, n, $urandom_range(0, 19) == 0);
			end else if (r < 82) begin
				n = $urandom_range(2, 6);
				send_code(pick_cp(n), n, $urandom_range(1, n - 1), 1'($urandom_range(0, 1)));
			end else begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
			end
		end
		// close any open sequence before the phase ends
		send_byte(8'h2E, 1'b1);
	endtask

	task automatic test_single_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_full_sequences();
		send_code(32'h0000_00A9, 2, 2, 1'b0);
		send_code(32'h7FFF_FFFF, 6, 6, 1'b0);
		send_code(32'h0000_0000, 2, 2, 1'b0);
		send_code(32'h0000_D800, 3, 3, 1'b0);
	endtask

	task automatic test_broken_and_truncated();
		send_byte(8'hE2, 1'b0);
		send_byte(8'hC2, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		send_byte(8'hC2, 1'b1);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h41, 1'b0);
	endtask

	task automatic test_back_to_back(input int n_bytes);
		src_quiet = 1'b1;
		snk_quiet = 1'b1;
		random_stream(n_bytes);
		src_quiet = 1'b0;
		snk_quiet = 1'b0;
	endtask

	task automatic test_result_backpressure(input int n_bytes);
		src_quiet    = 1'b1;
		hold_request = 1'b1;
		random_stream(n_bytes);
		src_quiet    = 1'b0;
	endtask

	initial begin
		arst_n                  = 1'b0;
		stream_if.valid         = 1'b0;
		stream_if.data_byte     = 8'd0;
		stream_if.end_of_stream = 1'b0;
		cfg_if.valid            = 1'b0;
		cfg_if.strict_mode      = 1'b1;
		strict_m                = 1'b1;
		clear_seq();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_bytes();
		test_full_sequences();
		test_broken_and_truncated();
		write_strict(1'b0);
		random_stream(300);
		write_strict(1'b1);
		random_stream(300);
		test_back_to_back(150);
		test_result_backpressure(40);
		write_strict(1'b0);
		random_stream(300);
		drain();

		$display("Sent %0d bytes, checked %0d results in %0d cycles.", bytes_sent,
			results_seen, cycles);
		$display({"By status: ok %0d, bad lead %0d, broken %0d, overlong %0d,",
			" strict %0d, truncated %0d"},
			seen_status[ST_OK], seen_status[ST_BAD_LEAD], seen_status[ST_BROKEN],
			seen_status[ST_OVERLONG], seen_status[ST_STRICT], seen_status[ST_TRUNCATED]);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
